// ===== sv/isfp_pkg.sv =====
// ----------------------------------------------------------------------------
// isfp_pkg
// Shared types and constants of the serial frame parser: frame layout,
// type codes, result kinds and the register map.
// ----------------------------------------------------------------------------
package isfp_pkg;

  // Frame layout: header, type, eight payload bytes, checksum
  localparam logic [7:0] HDR_BYTE  = 8'h55;
  localparam int         BODY_LEN  = 10;
  localparam logic [3:0] LAST_POS  = 4'd10;

  // Type byte codes
  localparam logic [7:0] TYPE_TIME  = 8'h50;
  localparam logic [7:0] TYPE_ACC   = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam logic [7:0] TYPE_QUAT  = 8'h59;
  localparam logic [7:0] TYPE_READ  = 8'h5F;

  // Register map: index taken from paddr[2]
  localparam logic REG_READ_START = 1'b0;

  // Result kind reported on tuser
  typedef enum logic [2:0] {
    KIND_TIME     = 3'd0,
    KIND_ACC      = 3'd1,
    KIND_GYRO     = 3'd2,
    KIND_ANGLE    = 3'd3,
    KIND_QUAT     = 3'd4,
    KIND_READ     = 3'd5,
    KIND_UNKNOWN  = 3'd6,
    KIND_CSUM_ERR = 3'd7
  } frame_kind_t;

  // Completed frame handed from the assembler to the result stage
  typedef struct packed {
    logic        csum_ok;
    logic [7:0]  type_code;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
  } frame_t;

endpackage

// ===== sv/isfp_apb_regs.sv =====
// ----------------------------------------------------------------------------
// isfp_apb_regs
// APB register file holding the requested register start address.
// ----------------------------------------------------------------------------
module isfp_apb_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  read_start_addr
);
  import isfp_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write the start address on a completed access
  always_ff @(posedge clk) begin
    if (rst) begin
      read_start_addr <= 8'd0;
    end else if (wr_en && (paddr[2] == REG_READ_START)) begin
      read_start_addr <= pwdata[7:0];
    end
  end

  // Read back
  always_comb begin
    if (paddr[2] == REG_READ_START) begin
      prdata = {24'd0, read_start_addr};
    end else begin
      prdata = 32'd0;
    end
  end

endmodule

// ===== sv/isfp_frame_asm.sv =====
// ----------------------------------------------------------------------------
// isfp_frame_asm
// Input register and frame assembler: header hunt, byte position, running
// checksum and frame store. Presents each completed frame to the result stage.
// ----------------------------------------------------------------------------
module isfp_frame_asm (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
  output logic                   frame_valid,
  output isfp_pkg::frame_t       frame,
  input  logic                   res_ready
);
  import isfp_pkg::*;

  logic       in_valid;
  logic       in_valid_next;
  logic [7:0] in_byte;
  logic [3:0] pos;
  logic [7:0] sum;
  logic [7:0] store [BODY_LEN];
  logic       at_csum;
  logic       step;
  logic       store_wr;

  // A checksum byte needs the result register; other bytes never wait
  assign at_csum       = (pos == LAST_POS);
  assign step          = in_valid && (!at_csum || res_ready);
  assign s_axis_tready = !in_valid || step;
  assign frame_valid   = in_valid && at_csum;
  assign store_wr      = step && ((pos == 4'd0) ? (in_byte == HDR_BYTE) : !at_csum);

  always_comb begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_next = 1'b1;
    end else if (step) begin
      in_valid_next = 1'b0;
    end else begin
      in_valid_next = in_valid;
    end
  end

  // Input register: hold valid
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  // Input register: capture byte on a transfer
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  // Advance position and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 4'd0;
      sum <= 8'd0;
    end else if (step) begin
      if (pos == 4'd0) begin
        if (in_byte == HDR_BYTE) begin
          pos <= 4'd1;
          sum <= in_byte;
        end
      end else if (!at_csum) begin
        pos <= pos + 4'd1;
        sum <= sum + in_byte;
      end else begin
        pos <= 4'd0;
      end
    end
  end

  // Frame store
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store[pos] <= in_byte;
    end
  end

  // Completed frame fields
  always_comb begin
    frame.csum_ok   = (in_byte == sum);
    frame.type_code = store[1];
    frame.word_a    = {store[3], store[2]};
    frame.word_b    = {store[5], store[4]};
    frame.word_c    = {store[7], store[6]};
    frame.word_d    = {store[9], store[8]};
  end

endmodule

// ===== sv/isfp_result.sv =====
// ----------------------------------------------------------------------------
// isfp_result
// Result stage: classify a completed frame, update the frame counters and the
// motion-set mask, and hold the result in the output register.
// ----------------------------------------------------------------------------
module isfp_result #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   frame_valid,
  input  isfp_pkg::frame_t       frame,
  output logic                   res_ready,
  input  logic [7:0]             read_start_addr,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] type_code, [23:8] word_a, [39:24] word_b, [55:40] word_c,
  // [71:56] word_d, [79:72] reg_addr_out, [80] sample_complete,
  // [112:81] good_frames, [144:113] bad_checksums, [176:145] unknown_frames,
  // [183:177] zero
  output logic [183:0]           m_axis_tdata,
  output logic [2:0]             m_axis_tuser    // [2:0] frame_kind
);
  import isfp_pkg::*;

  logic                   load;
  logic                   out_valid_next;
  logic [COUNT_WIDTH-1:0] good_count;
  logic [COUNT_WIDTH-1:0] bad_count;
  logic [COUNT_WIDTH-1:0] unrec_count;
  logic [COUNT_WIDTH-1:0] good_count_next;
  logic [COUNT_WIDTH-1:0] bad_count_next;
  logic [COUNT_WIDTH-1:0] unrec_count_next;
  logic [3:0]             seen_mask;
  logic [3:0]             seen_mask_next;
  logic [3:0]             seen_bit;
  logic [3:0]             seen_merged;
  frame_kind_t            kind;
  logic [7:0]             addr;
  logic                   pulse;

  // Output register
  frame_kind_t            kind_q;
  frame_t                 frame_q;
  logic [7:0]             addr_q;
  logic                   pulse_q;
  logic [31:0]            good_q;
  logic [31:0]            bad_q;
  logic [31:0]            unknown_q;

  assign res_ready = !m_axis_tvalid || m_axis_tready;
  assign load      = frame_valid && res_ready;

  // Classify the frame and update counters and the motion-set mask
  always_comb begin
    kind             = KIND_CSUM_ERR;
    addr             = 8'd0;
    seen_bit         = 4'd0;
    pulse            = 1'b0;
    good_count_next  = good_count;
    bad_count_next   = bad_count;
    unrec_count_next = unrec_count;
    seen_mask_next   = seen_mask;
    if (!frame.csum_ok) begin
      bad_count_next = bad_count + COUNT_WIDTH'(1);
      seen_mask_next = 4'd0;
    end else begin
      good_count_next = good_count + COUNT_WIDTH'(1);
      case (frame.type_code)
        TYPE_TIME:  kind = KIND_TIME;
        TYPE_ACC:   begin
          kind     = KIND_ACC;
          seen_bit = 4'b0001;
        end
        TYPE_GYRO:  begin
          kind     = KIND_GYRO;
          seen_bit = 4'b0010;
        end
        TYPE_ANGLE: begin
          kind     = KIND_ANGLE;
          seen_bit = 4'b0100;
        end
        TYPE_QUAT:  begin
          kind     = KIND_QUAT;
          seen_bit = 4'b1000;
        end
        TYPE_READ:  begin
          kind = KIND_READ;
          addr = read_start_addr;
        end
        default: begin
          kind             = KIND_UNKNOWN;
          unrec_count_next = unrec_count + COUNT_WIDTH'(1);
          seen_mask_next   = 4'd0;
        end
      endcase
    end
    seen_merged = seen_mask | seen_bit;
    if (seen_bit != 4'd0) begin
      if (seen_merged == 4'hF) begin
        pulse          = 1'b1;
        seen_mask_next = 4'd0;
      end else begin
        seen_mask_next = seen_merged;
      end
    end
  end

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = m_axis_tvalid;
    end
  end

  // Control state: counters, mask, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      good_count    <= '0;
      bad_count     <= '0;
      unrec_count   <= '0;
      seen_mask     <= 4'd0;
    end else begin
      m_axis_tvalid <= out_valid_next;
      if (load) begin
        good_count  <= good_count_next;
        bad_count   <= bad_count_next;
        unrec_count <= unrec_count_next;
        seen_mask   <= seen_mask_next;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      kind_q    <= kind;
      frame_q   <= frame;
      addr_q    <= addr;
      pulse_q   <= pulse;
      good_q    <= 32'(good_count_next);
      bad_q     <= 32'(bad_count_next);
      unknown_q <= 32'(unrec_count_next);
    end
  end

  assign m_axis_tuser = kind_q;
  assign m_axis_tdata = {7'd0, unknown_q, bad_q, good_q, pulse_q, addr_q,
                         frame_q.word_d, frame_q.word_c, frame_q.word_b,
                         frame_q.word_a, frame_q.type_code};

endmodule

// ===== sv/imu_serial_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// imu_serial_frame_parser_core
// Checksummed 11-byte frame parser for an inertial sensor serial link.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle, except while a checksum byte waits
// in the input register for the result register to be free.
// A frame result goes from the input register, which holds its checksum byte,
// into the result register once that is free, and from there to the master side.
// Reset (rst, synchronous, active high) returns to header hunt and clears the
// counters, the motion-set mask and the start address register.
module imu_serial_frame_parser_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] type_code, [23:8] word_a, [39:24] word_b, [55:40] word_c,
  // [71:56] word_d, [79:72] reg_addr_out, [80] sample_complete,
  // [112:81] good_frames, [144:113] bad_checksums, [176:145] unknown_frames,
  // [183:177] zero
  output logic [183:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // [2:0] frame_kind
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import isfp_pkg::*;

  logic       frame_valid;
  frame_t     frame;
  logic       res_ready;
  logic [7:0] read_start_addr;

  isfp_apb_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .read_start_addr (read_start_addr)
  );

  isfp_frame_asm u_asm (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .frame_valid   (frame_valid),
    .frame         (frame),
    .res_ready     (res_ready)
  );

  isfp_result #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_result (
    .clk             (clk),
    .rst             (rst),
    .frame_valid     (frame_valid),
    .frame           (frame),
    .res_ready       (res_ready),
    .read_start_addr (read_start_addr),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser)
  );

endmodule

// ===== bench/imu_serial_frame_parser_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_serial_frame_parser_core_tb
// Streams received bytes into the frame parser and checks every completed
// frame result field by field. A local model of the parser tracks the frame
// position, running sum, motion-set mask and counters, and queues the result
// each accepted checksum byte should produce. Traffic runs in phases with
// different start addresses and different sender and receiver idling.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser_core_tb;
  import isfp_pkg::*;

  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_BYTES   = 275;

  // Register map: start address register, and an address past the list
  localparam logic [2:0] ADDR_READ_START = {REG_READ_START, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;

  // Motion-set mask bits
  localparam logic [3:0] SEEN_ACC   = 4'b0001;
  localparam logic [3:0] SEEN_GYRO  = 4'b0010;
  localparam logic [3:0] SEEN_ANGLE = 4'b0100;
  localparam logic [3:0] SEEN_QUAT  = 4'b1000;
  localparam logic [3:0] SEEN_ALL   = 4'b1111;

  typedef struct {
    frame_kind_t kind;
    logic [7:0]  type_code;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    logic [7:0]  reg_addr;
    logic        sample_complete;
    logic [31:0] good_frames;
    logic [31:0] bad_checksums;
    logic [31:0] unknown_frames;
  } frame_report_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;    // [7:0] rx_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [7:0] type_code, [23:8] word_a, [39:24] word_b, [55:40] word_c,
  // [71:56] word_d, [79:72] reg_addr_out, [80] sample_complete,
  // [112:81] good_frames, [144:113] bad_checksums, [176:145] unknown_frames,
  // [183:177] zero
  logic [183:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;            // [2:0] frame_kind
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = 3'd0;
  logic [31:0]  pwdata = 32'd0;
  logic [31:0]  prdata;
  logic         pready;

  // Stimulus and expectations
  logic [7:0]    rx_bytes[$];
  frame_report_t pending_reports[$];
  int            bytes_queued = 0;
  int            mismatches = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            quiet_cycles = 0;

  // Parser model state
  logic [3:0]  frame_pos = 4'd0;
  logic [7:0]  frame_bytes [0:9];
  logic [7:0]  frame_sum = 8'd0;
  logic [3:0]  seen_set = 4'd0;
  logic [31:0] good_total = 32'd0;
  logic [31:0] bad_total = 32'd0;
  logic [31:0] unknown_total = 32'd0;
  logic [7:0]  read_start = 8'd0;

  imu_serial_frame_parser_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advance the parser model by one received byte; queue a result at the
  // checksum byte
  task automatic parse_rx_byte(input logic [7:0] rx);
    frame_report_t rep;
    logic [3:0]    seen_bit;
    if (frame_pos == 4'd0) begin
      if (rx == HDR_BYTE) begin
        frame_bytes[0] = rx;
        frame_sum = rx;
        frame_pos = 4'd1;
      end
    end else if (frame_pos < LAST_POS) begin
      frame_bytes[frame_pos] = rx;
      frame_sum = frame_sum + rx;
      frame_pos = frame_pos + 4'd1;
    end else begin
      frame_pos = 4'd0;
      seen_bit = 4'd0;
      rep.type_code = frame_bytes[1];
      rep.word_a = {frame_bytes[3], frame_bytes[2]};
      rep.word_b = {frame_bytes[5], frame_bytes[4]};
      rep.word_c = {frame_bytes[7], frame_bytes[6]};
      rep.word_d = {frame_bytes[9], frame_bytes[8]};
      rep.reg_addr = 8'd0;
      rep.sample_complete = 1'b0;
      if (rx != frame_sum) begin
        rep.kind = KIND_CSUM_ERR;
        bad_total = bad_total + 32'd1;
        seen_set = 4'd0;
      end else begin
        good_total = good_total + 32'd1;
        case (frame_bytes[1])
          TYPE_TIME: rep.kind = KIND_TIME;
          TYPE_ACC: begin
            rep.kind = KIND_ACC;
            seen_bit = SEEN_ACC;
          end
          TYPE_GYRO: begin
            rep.kind = KIND_GYRO;
            seen_bit = SEEN_GYRO;
          end
          TYPE_ANGLE: begin
            rep.kind = KIND_ANGLE;
            seen_bit = SEEN_ANGLE;
          end
          TYPE_QUAT: begin
            rep.kind = KIND_QUAT;
            seen_bit = SEEN_QUAT;
          end
          TYPE_READ: begin
            rep.kind = KIND_READ;
            rep.reg_addr = read_start;
          end
          default: begin
            rep.kind = KIND_UNKNOWN;
            unknown_total = unknown_total + 32'd1;
            seen_set = 4'd0;
          end
        endcase
        // Close the motion set once all four types are in
        if (seen_bit != 4'd0) begin
          seen_set = seen_set | seen_bit;
          if (seen_set == SEEN_ALL) begin
            rep.sample_complete = 1'b1;
            seen_set = 4'd0;
          end
        end
      end
      rep.good_frames = good_total;
      rep.bad_checksums = bad_total;
      rep.unknown_frames = unknown_total;
      pending_reports.push_back(rep);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic queue_rx(input logic [7:0] rx);
    rx_bytes.push_back(rx);
    bytes_queued++;
  endtask

  // Build one frame; optionally corrupt the checksum or cut trailing bytes
  task automatic add_frame(input logic [7:0] type_code, input logic [63:0] payload,
                           input bit corrupt, input int cut);
    logic [7:0] body [0:10];
    logic [7:0] sum;
    body[0] = HDR_BYTE;
    body[1] = type_code;
    for (int i = 0; i < 8; i++) body[i + 2] = payload[8 * i +: 8];
    sum = 8'd0;
    for (int i = 0; i < 10; i++) sum = sum + body[i];
    body[10] = corrupt ? sum + 8'($urandom_range(1, 255)) : sum;
    for (int i = 0; i < 11 - cut; i++) queue_rx(body[i]);
  endtask

  // Mostly well-formed frames with random content, some noise and broken ones
  task automatic add_random_traffic(input int count);
    int         target;
    int         pick;
    logic [7:0] ftype;
    target = bytes_queued + count;
    while (bytes_queued < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) queue_rx(8'($urandom));
      end
      pick = $urandom_range(0, 6);
      case (pick)
        0: ftype = TYPE_TIME;
        1: ftype = TYPE_ACC;
        2: ftype = TYPE_GYRO;
        3: ftype = TYPE_ANGLE;
        4: ftype = TYPE_QUAT;
        5: ftype = TYPE_READ;
        default: ftype = 8'($urandom);
      endcase
      add_frame(ftype, {$urandom, $urandom}, $urandom_range(0, 7) == 0,
                ($urandom_range(0, 19) == 0) ? $urandom_range(1, 10) : 0);
    end
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_READ_START) read_start = data[7:0];
  endtask

  // Hold until every byte is in and every result is out, then let it settle
  task automatic wait_drained();
    while (rx_bytes.size() != 0 || s_axis_tvalid || pending_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Byte driver: predict on each transfer, then offer the next byte or idle
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_rx_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= rx_bytes.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin : result_monitor
    frame_report_t rep;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_reports.size() == 0) begin
          $error("frame result with no expectation waiting: kind 0x%0h type 0x%0h",
                 m_axis_tuser, m_axis_tdata[7:0]);
          mismatches++;
        end else begin
          rep = pending_reports.pop_front();
          compare_field("frame_kind", 32'(rep.kind), 32'(m_axis_tuser));
          compare_field("type_code", 32'(rep.type_code), 32'(m_axis_tdata[7:0]));
          compare_field("word_a", 32'(rep.word_a), 32'(m_axis_tdata[23:8]));
          compare_field("word_b", 32'(rep.word_b), 32'(m_axis_tdata[39:24]));
          compare_field("word_c", 32'(rep.word_c), 32'(m_axis_tdata[55:40]));
          compare_field("word_d", 32'(rep.word_d), 32'(m_axis_tdata[71:56]));
          compare_field("reg_addr_out", 32'(rep.reg_addr), 32'(m_axis_tdata[79:72]));
          compare_field("sample_complete", 32'(rep.sample_complete),
                        32'(m_axis_tdata[80]));
          compare_field("good_frames", rep.good_frames, m_axis_tdata[112:81]);
          compare_field("bad_checksums", rep.bad_checksums, m_axis_tdata[144:113]);
          compare_field("unknown_frames", rep.unknown_frames, m_axis_tdata[176:145]);
          compare_field("tdata padding", 32'd0, 32'(m_axis_tdata[183:177]));
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: lowest start address, write past the map is ignored, no idling
    apb_write(ADDR_READ_START, 32'h0000_0000);
    apb_write(ADDR_UNMAPPED, 32'h0000_003C);
    send_idle_pct = 0;
    recv_stall_pct = 0;

    // Noise while hunting for the header is dropped
    queue_rx(8'h00);
    queue_rx(8'hFF);
    queue_rx(8'h54);
    // Every type; extremes of payload; header value inside a frame is data
    add_frame(TYPE_TIME, 64'h0, 1'b0, 0);
    add_frame(TYPE_ACC, {8{8'hFF}}, 1'b0, 0);
    add_frame(TYPE_GYRO, {8{8'h55}}, 1'b0, 0);
    add_frame(TYPE_ANGLE, 64'h0123_4567_89AB_CDEF, 1'b0, 0);
    // Time frame leaves the set alone; quaternion completes it
    add_frame(TYPE_TIME, {$urandom, $urandom}, 1'b0, 0);
    add_frame(TYPE_QUAT, {$urandom, $urandom}, 1'b0, 0);
    add_frame(TYPE_READ, {$urandom, $urandom}, 1'b0, 0);
    add_frame(8'hFF, {$urandom, $urandom}, 1'b0, 0);
    add_frame(8'h00, {$urandom, $urandom}, 1'b0, 0);
    // Checksum error clears a partly built set
    add_frame(TYPE_ACC, {$urandom, $urandom}, 1'b0, 0);
    add_frame(TYPE_GYRO, {$urandom, $urandom}, 1'b1, 0);
    add_frame(TYPE_ANGLE, {$urandom, $urandom}, 1'b0, 0);
    add_frame(TYPE_QUAT, {$urandom, $urandom}, 1'b0, 0);
    // Unknown type clears it too
    add_frame(TYPE_ACC, {$urandom, $urandom}, 1'b0, 0);
    add_frame(TYPE_GYRO, {$urandom, $urandom}, 1'b0, 0);
    add_frame(8'h5A, {$urandom, $urandom}, 1'b0, 0);
    add_frame(TYPE_QUAT, {$urandom, $urandom}, 1'b0, 0);
    add_random_traffic(PHASE_BYTES);
    wait_drained();

    // Phase 2: highest start address, sender idles
    apb_write(ADDR_READ_START, 32'h0000_00FF);
    send_idle_pct = 49;
    recv_stall_pct = 0;
    add_frame(TYPE_READ, {$urandom, $urandom}, 1'b0, 0);
    add_random_traffic(PHASE_BYTES);
    wait_drained();

    // Phase 3: random start address, receiver stalls
    apb_write(ADDR_READ_START, $urandom);
    send_idle_pct = 0;
    recv_stall_pct = 49;
    add_random_traffic(PHASE_BYTES);
    wait_drained();

    // Phase 4: another random address, light idling on both sides
    apb_write(ADDR_UNMAPPED, $urandom);
    apb_write(ADDR_READ_START, $urandom);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    add_random_traffic(PHASE_BYTES);
    wait_drained();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/isfp_pkg.sv
sv/isfp_apb_regs.sv
sv/isfp_frame_asm.sv
sv/isfp_result.sv
sv/imu_serial_frame_parser_core.sv
bench/imu_serial_frame_parser_core_tb.sv
